// File: hw/rtl/cache_line_replacement_core_assert.svh
// Assertion macros for the cache line replacement core
`ifndef CACHE_LINE_REPLACEMENT_CORE_ASSERT_SVH
`define CACHE_LINE_REPLACEMENT_CORE_ASSERT_SVH

// Same-cycle implication under reset
`define CLR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under reset
`define CLR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/clr_pkg.sv
// Shared types and constants of the cache line replacement core
package clr_pkg;

  localparam int SIZE_W   = 24;
  localparam int OFF_W    = 32;
  localparam int TYPE_W   = 8;
  localparam int TAG_W    = TYPE_W + OFF_W + SIZE_W;
  localparam int DIV_STEPS = SIZE_W;
  localparam int MAX_RESULTS = 16;

  // result status codes
  localparam logic [2:0] ST_HIT   = 3'd0;
  localparam logic [2:0] ST_MISS  = 3'd1;
  localparam logic [2:0] ST_BIG   = 3'd2;
  localparam logic [2:0] ST_LINES = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;
  localparam logic [2:0] ST_CLEAR = 3'd5;

  // replacement policy codes (the spare code behaves as fifo)
  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_LRU  = 2'd1;
  localparam logic [1:0] POL_LFU  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_POLICY = 2'd0;
  localparam logic [1:0] CFG_LCOUNT = 2'd1;
  localparam logic [1:0] CFG_LSIZE  = 2'd2;
  localparam logic [1:0] CFG_TOTAL  = 2'd3;

  typedef struct packed {
    logic              start;
    logic [SIZE_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] quot;
    logic [SIZE_W-1:0] rem;
  } div_res_t;

endpackage

// File: hw/rtl/clr_div.sv
// Restoring radix-2 divider, one quotient bit per cycle
module clr_div (
  input  logic             clk,
  input  logic             rst_n,
  input  clr_pkg::div_req_t req,
  output clr_pkg::div_res_t res
);

  logic                       busy_r;
  logic                       done_r;
  logic [4:0]                 cnt_r;
  logic [clr_pkg::SIZE_W-1:0] q_r;
  logic [clr_pkg::SIZE_W-1:0] r_r;
  logic [clr_pkg::SIZE_W-1:0] d_r;
  logic [clr_pkg::SIZE_W:0]   trial;
  logic [clr_pkg::SIZE_W:0]   diff;
  logic                       ge;

  // trial subtract of the shifted partial remainder
  assign trial = {r_r, q_r[clr_pkg::SIZE_W-1]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = trial >= {1'b0, d_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(clr_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r <= req.dividend;
      r_r <= '0;
      d_r <= req.divisor;
    end else if (busy_r) begin
      r_r <= ge ? diff[clr_pkg::SIZE_W-1:0] : trial[clr_pkg::SIZE_W-1:0];
      q_r <= {q_r[clr_pkg::SIZE_W-2:0], ge};
    end
  end

  assign res.done = done_r;
  assign res.quot = q_r;
  assign res.rem  = r_r;

endmodule

// File: hw/rtl/cache_line_replacement_core.sv
// Cache line replacement core: request sequencer, line table and victim search.
// A clear or a size error goes straight to the output; other errors follow the
// division and chunk count check. A load then, per chunk, scans the lines in use
// for a tag match, fills the victim line on a miss and, with LRU/LFU, scans them
// again for the next victim, reading the line table one line per cycle. One request
// is in flight at a time. Reset (rst_n low, synchronous) empties the table and
// loads the register defaults.
module cache_line_replacement_core #(
  parameter int NUM_LINES    = 16,
  parameter int COUNTER_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_req_type,
  input  logic [31:0] in_req_offset,
  input  logic [23:0] in_req_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [3:0]  out_line,
  output logic [31:0] out_chunk_offset,
  output logic [23:0] out_chunk_size,
  output logic        out_last
);

  `include "cache_line_replacement_core_assert.svh"

  localparam int IW  = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int LCW = $clog2(NUM_LINES + 1);
  localparam int CW  = COUNTER_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_SCAN1 = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_SCAN2 = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  // configuration
  logic [1:0]  policy_r, policy_nxt;
  logic [4:0]  lcount_r, lcount_nxt;
  logic [23:0] lsize_r, lsize_nxt;
  logic [23:0] total_r, total_nxt;

  // sequencer
  logic [2:0]      state_r, state_nxt;
  logic [LCW-1:0]  sc_r, sc_nxt;
  logic            pv_r, pv_nxt;
  logic [IW-1:0]   pidx_r, pidx_nxt;
  logic            hit_r, hit_nxt;
  logic [IW-1:0]   ln_r, ln_nxt;
  logic [IW-1:0]   vp_r, vp_nxt;
  logic [IW-1:0]   best_r, best_nxt;
  logic [CW-1:0]   bcnt_r, bcnt_nxt;
  logic [4:0]      ci_r, ci_nxt;
  logic [4:0]      need_r, need_nxt;
  logic [7:0]      typ_r, typ_nxt;
  logic [31:0]     coff_r, coff_nxt;
  logic [23:0]     csz_r, csz_nxt;
  logic [23:0]     lastsz_r, lastsz_nxt;
  logic [23:0]     ls_r, ls_nxt;
  logic            em_chunk_r, em_chunk_nxt;
  logic [2:0]      em_st_r, em_st_nxt;
  logic [NUM_LINES-1:0] lvalid_r, lvalid_nxt;
  logic [NUM_LINES-1:0] cnt_ok_r, cnt_ok_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [3:0]  out_line_r, out_line_nxt;
  logic [31:0] out_coff_r, out_coff_nxt;
  logic [23:0] out_csz_r, out_csz_nxt;
  logic        out_last_r, out_last_nxt;

  // line table memories and read stage
  logic [clr_pkg::TAG_W-1:0] tag_mem [NUM_LINES];
  logic [CW-1:0]             cnt_mem [NUM_LINES];
  logic [clr_pkg::TAG_W-1:0] tag_q;
  logic [CW-1:0]             cnt_q;
  logic                      lv_q;
  logic                      ok_q;
  logic [IW-1:0]             rd_addr;

  logic                      tag_we;
  logic [IW-1:0]             tag_wa;
  logic                      cnt_we;
  logic [IW-1:0]             cnt_wa;
  logic [CW-1:0]             cnt_wd;

  clr_pkg::div_req_t div_req;
  clr_pkg::div_res_t div_res;

  logic [LCW-1:0] lc;
  logic [23:0]    ls_eff;
  logic [24:0]    need_w;
  logic [CW-1:0]  cur_cnt;
  logic [CW-1:0]  cur_inc;
  logic           match;
  logic           lru_or_lfu;
  logic           in_take;
  logic           out_free;
  logic           do_clear;
  logic           chunk_last;
  logic [IW-1:0]  vpe;

  clr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  // effective line count and line size
  always_comb begin
    if (lcount_r == 5'd0) begin
      lc = LCW'(1);
    end else if (lcount_r > NUM_LINES) begin
      lc = LCW'(NUM_LINES);
    end else begin
      lc = LCW'(lcount_r);
    end
  end

  assign ls_eff     = (lsize_r == 24'd0) ? 24'd1 : lsize_r;
  assign need_w     = {1'b0, div_res.quot} + 25'(div_res.rem != '0);
  assign cur_cnt    = ok_q ? cnt_q : '0;
  assign cur_inc    = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;
  assign match      = lv_q && (tag_q == {typ_r, coff_r, csz_r});
  assign lru_or_lfu = (policy_r == clr_pkg::POL_LRU) || (policy_r == clr_pkg::POL_LFU);
  assign in_stall   = (state_r != S_IDLE);
  assign in_take    = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign chunk_last = (ci_r + 5'd1) == need_r;
  assign vpe        = (LCW'(vp_r) < lc) ? vp_r : '0;
  assign rd_addr    = sc_r[IW-1:0];
  assign do_clear   = (in_take && in_opcode) || (cfg_we && cfg_idx != clr_pkg::CFG_TOTAL);

  // sequencer next state
  always_comb begin
    policy_nxt   = policy_r;
    lcount_nxt   = lcount_r;
    lsize_nxt    = lsize_r;
    total_nxt    = total_r;
    state_nxt    = state_r;
    sc_nxt       = sc_r;
    pv_nxt       = pv_r;
    pidx_nxt     = pidx_r;
    hit_nxt      = hit_r;
    ln_nxt       = ln_r;
    vp_nxt       = vp_r;
    best_nxt     = best_r;
    bcnt_nxt     = bcnt_r;
    ci_nxt       = ci_r;
    need_nxt     = need_r;
    typ_nxt      = typ_r;
    coff_nxt     = coff_r;
    csz_nxt      = csz_r;
    lastsz_nxt   = lastsz_r;
    ls_nxt       = ls_r;
    em_chunk_nxt = em_chunk_r;
    em_st_nxt    = em_st_r;
    lvalid_nxt   = lvalid_r;
    cnt_ok_nxt   = cnt_ok_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_line_nxt   = out_line_r;
    out_coff_nxt   = out_coff_r;
    out_csz_nxt    = out_csz_r;
    out_last_nxt   = out_last_r;
    tag_we  = 1'b0;
    tag_wa  = vpe;
    cnt_we  = 1'b0;
    cnt_wa  = pidx_r;
    cnt_wd  = '0;
    div_req = '0;

    // scan pointer advances one line a cycle in both passes
    if (state_r == S_SCAN1 || state_r == S_SCAN2) begin
      if (sc_r < lc) begin
        pv_nxt   = 1'b1;
        pidx_nxt = sc_r[IW-1:0];
        sc_nxt   = sc_r + 1'b1;
      end else begin
        pv_nxt = 1'b0;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_opcode) begin
            em_chunk_nxt = 1'b0;
            em_st_nxt    = clr_pkg::ST_CLEAR;
            state_nxt    = S_EMIT;
          end else if (in_req_size > total_r) begin
            em_chunk_nxt = 1'b0;
            em_st_nxt    = clr_pkg::ST_BIG;
            state_nxt    = S_EMIT;
          end else begin
            typ_nxt  = in_req_type;
            coff_nxt = in_req_offset;
            ls_nxt   = ls_eff;
            div_req.start    = 1'b1;
            div_req.dividend = in_req_size;
            div_req.divisor  = ls_eff;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        // check the chunk count, then set up the first chunk
        if (div_res.done) begin
          if (need_w > lc || need_w > clr_pkg::MAX_RESULTS) begin
            em_chunk_nxt = 1'b0;
            em_st_nxt    = clr_pkg::ST_LINES;
            state_nxt    = S_EMIT;
          end else if (need_w == 25'd0) begin
            em_chunk_nxt = 1'b0;
            em_st_nxt    = clr_pkg::ST_EMPTY;
            state_nxt    = S_EMIT;
          end else begin
            need_nxt     = need_w[4:0];
            lastsz_nxt   = (div_res.rem != '0) ? div_res.rem : ls_r;
            csz_nxt      = (need_w == 25'd1) ?
                           ((div_res.rem != '0) ? div_res.rem : ls_r) : ls_r;
            ci_nxt       = '0;
            em_chunk_nxt = 1'b1;
            hit_nxt      = 1'b0;
            sc_nxt       = '0;
            pv_nxt       = 1'b0;
            state_nxt    = S_SCAN1;
          end
        end
      end
      S_SCAN1: begin
        // tag compare and counter update of one line
        if (pv_r) begin
          if (match && !hit_r) begin
            hit_nxt = 1'b1;
            ln_nxt  = pidx_r;
          end
          if (policy_r == clr_pkg::POL_LRU) begin
            cnt_we = 1'b1;
            cnt_wd = match ? '0 : cur_inc;
          end else if (policy_r == clr_pkg::POL_LFU && match) begin
            cnt_we = 1'b1;
            cnt_wd = cur_inc;
          end
        end
        if (sc_r == lc && !pv_r) begin
          sc_nxt = '0;
          if (!hit_r) begin
            state_nxt = S_FILL;
          end else if (lru_or_lfu) begin
            state_nxt = S_SCAN2;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_FILL: begin
        // fill the victim line
        lvalid_nxt[vpe] = 1'b1;
        tag_we = 1'b1;
        ln_nxt = vpe;
        cnt_wa = vpe;
        if (policy_r == clr_pkg::POL_LRU) begin
          cnt_we = 1'b1;
          cnt_wd = '0;
        end else if (policy_r == clr_pkg::POL_LFU) begin
          cnt_we = 1'b1;
          cnt_wd = CW'(1);
        end
        if (lru_or_lfu) begin
          state_nxt = S_SCAN2;
        end else begin
          vp_nxt    = ((LCW'(vpe) + 1'b1) == lc) ? '0 : IW'(LCW'(vpe) + 1'b1);
          state_nxt = S_EMIT;
        end
      end
      S_SCAN2: begin
        // first oldest or least used line
        if (pv_r) begin
          if (pidx_r == '0 ||
              (policy_r == clr_pkg::POL_LRU ? cur_cnt > bcnt_r : cur_cnt < bcnt_r)) begin
            best_nxt = pidx_r;
            bcnt_nxt = cur_cnt;
          end
        end
        if (sc_r == lc && !pv_r) begin
          vp_nxt    = best_r;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // hand the beat to the output register, then advance
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (em_chunk_r) begin
            out_status_nxt = hit_r ? clr_pkg::ST_HIT : clr_pkg::ST_MISS;
            out_line_nxt   = 4'(ln_r);
            out_coff_nxt   = coff_r;
            out_csz_nxt    = csz_r;
            out_last_nxt   = chunk_last;
          end else begin
            out_status_nxt = em_st_r;
            out_line_nxt   = '0;
            out_coff_nxt   = '0;
            out_csz_nxt    = '0;
            out_last_nxt   = 1'b1;
          end
          if (!em_chunk_r || chunk_last) begin
            state_nxt = S_IDLE;
          end else begin
            ci_nxt    = ci_r + 5'd1;
            coff_nxt  = coff_r + {8'd0, ls_r};
            csz_nxt   = ((ci_r + 5'd2) == need_r) ? lastsz_r : ls_r;
            hit_nxt   = 1'b0;
            sc_nxt    = '0;
            pv_nxt    = 1'b0;
            state_nxt = S_SCAN1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // configuration writes
    if (cfg_we) begin
      case (cfg_idx)
        clr_pkg::CFG_POLICY: policy_nxt = cfg_data[1:0];
        clr_pkg::CFG_LCOUNT: lcount_nxt = cfg_data[4:0];
        clr_pkg::CFG_LSIZE:  lsize_nxt  = cfg_data;
        clr_pkg::CFG_TOTAL:  total_nxt  = cfg_data;
        default: ;
      endcase
    end

    if (cnt_we) begin
      cnt_ok_nxt[cnt_wa] = 1'b1;
    end

    // drop all lines and counters
    if (do_clear) begin
      lvalid_nxt = '0;
      cnt_ok_nxt = '0;
      vp_nxt     = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= clr_pkg::POL_FIFO;
      lcount_r    <= 5'd16;
      lsize_r     <= 24'd256;
      total_r     <= 24'd4096;
      state_r     <= S_IDLE;
      pv_r        <= 1'b0;
      vp_r        <= '0;
      lvalid_r    <= '0;
      cnt_ok_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      policy_r    <= policy_nxt;
      lcount_r    <= lcount_nxt;
      lsize_r     <= lsize_nxt;
      total_r     <= total_nxt;
      state_r     <= state_nxt;
      pv_r        <= pv_nxt;
      vp_r        <= vp_nxt;
      lvalid_r    <= lvalid_nxt;
      cnt_ok_r    <= cnt_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sc_r         <= sc_nxt;
    pidx_r       <= pidx_nxt;
    hit_r        <= hit_nxt;
    ln_r         <= ln_nxt;
    best_r       <= best_nxt;
    bcnt_r       <= bcnt_nxt;
    ci_r         <= ci_nxt;
    need_r       <= need_nxt;
    typ_r        <= typ_nxt;
    coff_r       <= coff_nxt;
    csz_r        <= csz_nxt;
    lastsz_r     <= lastsz_nxt;
    ls_r         <= ls_nxt;
    em_chunk_r   <= em_chunk_nxt;
    em_st_r      <= em_st_nxt;
    out_status_r <= out_status_nxt;
    out_line_r   <= out_line_nxt;
    out_coff_r   <= out_coff_nxt;
    out_csz_r    <= out_csz_nxt;
    out_last_r   <= out_last_nxt;
  end

  // line table: one write, one registered read per memory
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= {typ_r, coff_r, csz_r};
    end
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    tag_q <= tag_mem[rd_addr];
    cnt_q <= cnt_mem[rd_addr];
    lv_q  <= lvalid_r[rd_addr];
    ok_q  <= cnt_ok_r[rd_addr];
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_line         = out_line_r;
  assign out_chunk_offset = out_coff_r;
  assign out_chunk_size   = out_csz_r;
  assign out_last         = out_last_r;

  `CLR_ASSERT_IMP(a_scan_idx, pv_r, LCW'(pidx_r) < lc, "scan index beyond lines in use")
  `CLR_ASSERT_IMP(a_chunk_cnt, state_r == S_SCAN1, need_r != '0 && ci_r < need_r, "bad chunk")
  `CLR_ASSERT_NXT(a_fill_next, state_r == S_FILL, state_r == S_SCAN2 || state_r == S_EMIT, "fill")

endmodule
